[rtl/core/txcon_pkg.sv]
package txcon_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [15:0] BLANK_CELL   = 16'h0020;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [3:0] fore_color;
        logic [3:0] back_color;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } t_result;

    // logical row to physical row of the ring, row and top both below ROWS
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // physical row and column to cell address
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

[rtl/core/text_console_cursor_scroll.sv]
// Text console of ROWS x COLUMNS 16-bit cells (attribute byte, then character
// byte) with a cursor. Pulse start while busy is low to hand in one beat; the
// result beat appears on o_result with o_done high for exactly one cycle and
// must be taken then, as there is no way to hold it off. A character write,
// a newline, a cell read or an unused mode passes through the exec state
// and returns to idle. A write that moves the cursor below the bottom row
// scrolls: rows live in a ring behind a top-row pointer, so a scroll only
// blanks one row through the single memory write port. A clear walks every
// cell through that port. After reset the same clearing pass runs with busy
// high and produces no result beat.
module text_console_cursor_scroll
    import txcon_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_CLEAR  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_item  r_item, n_item;

    // cursor in logical coordinates, top is the physical row shown first
    logic [ROW_W-1:0]  r_cur_y, n_cur_y;
    logic [COL_W-1:0]  r_cur_x, n_cur_x;
    logic [ROW_W-1:0]  r_top, n_top;

    // sweep address counter shared by scroll blanking and clearing
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [ADDR_W-1:0] r_sweep_last, n_sweep_last;
    logic              r_report, n_report;

    logic              r_done, n_done;
    t_result           r_result, n_result;

    // cell store, one write and one registered read port
    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd_data;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;

    // cursor advance
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] top_base;
    logic              is_newline;
    logic [COL_W:0]    x_inc;
    logic              wrap_line;
    logic [ROW_W:0]    y_inc;
    logic              need_scroll;
    logic              exec_in_range;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // read address follows the input beat so the cell is ready in the exec cycle
    always_comb begin
        rd_in_range = (32'(i_item.read_row) < ROWS) && (32'(i_item.read_column) < COLUMNS);
        rd_addr     = '0;
        if (rd_in_range) begin
            rd_addr = cell_addr(wrap_row(ROW_W'(i_item.read_row), r_top),
                                COL_W'(i_item.read_column));
        end
    end

    always_comb begin
        cur_addr      = cell_addr(wrap_row(r_cur_y, r_top), r_cur_x);
        top_base      = cell_addr(r_top, '0);
        is_newline    = (r_item.char_code == NEWLINE_CODE);
        x_inc         = {1'b0, r_cur_x} + (COL_W+1)'(1);
        wrap_line     = is_newline || (x_inc >= (COL_W+1)'(COLUMNS));
        y_inc         = {1'b0, r_cur_y} + (ROW_W+1)'(1);
        need_scroll   = wrap_line && (y_inc >= (ROW_W+1)'(ROWS));
        exec_in_range = (32'(r_item.read_row) < ROWS) && (32'(r_item.read_column) < COLUMNS);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_cur_y      = r_cur_y;
        n_cur_x      = r_cur_x;
        n_top        = r_top;
        n_sweep      = r_sweep;
        n_sweep_last = r_sweep_last;
        n_report     = r_report;
        n_done       = 1'b0;
        n_result     = r_result;
        mem_we       = 1'b0;
        mem_waddr    = r_sweep;
        mem_wdata    = BLANK_CELL;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_result.cell_word = '0;
                case (r_item.mode)
                    MODE_WRITE: begin
                        if (!is_newline) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr;
                            mem_wdata = {r_item.back_color, r_item.fore_color,
                                         r_item.char_code};
                        end
                        if (need_scroll) begin
                            // old top row becomes the new bottom row, blank it
                            n_cur_x      = '0;
                            n_cur_y      = ROW_W'(ROWS - 1);
                            n_top        = wrap_row(ROW_W'(1), r_top);
                            n_sweep      = top_base;
                            n_sweep_last = top_base + ADDR_W'(COLUMNS - 1);
                            n_report     = 1'b1;
                            n_state      = S_SCROLL;
                        end else begin
                            if (wrap_line) begin
                                n_cur_x = '0;
                                n_cur_y = y_inc[ROW_W-1:0];
                            end else begin
                                n_cur_x = x_inc[COL_W-1:0];
                            end
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    MODE_CLEAR: begin
                        n_cur_x      = '0;
                        n_cur_y      = '0;
                        n_top        = '0;
                        n_sweep      = '0;
                        n_sweep_last = ADDR_W'(CELLS - 1);
                        n_report     = 1'b1;
                        n_state      = S_CLEAR;
                    end
                    MODE_READ: begin
                        if (exec_in_range) begin
                            n_result.cell_word = r_rd_data;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        // unused mode leaves everything as it is
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
                n_result.cursor_row    = 5'(n_cur_y);
                n_result.cursor_column = 7'(n_cur_x);
            end

            S_SCROLL, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                if (r_sweep == r_sweep_last) begin
                    n_done                 = r_report;
                    n_result.cell_word     = '0;
                    n_result.cursor_row    = 5'(r_cur_y);
                    n_result.cursor_column = 7'(r_cur_x);
                    n_state                = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cur_y      <= '0;
            r_cur_x      <= '0;
            r_top        <= '0;
            r_sweep      <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
            r_report     <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur_y      <= n_cur_y;
            r_cur_x      <= n_cur_x;
            r_top        <= n_top;
            r_sweep      <= n_sweep;
            r_sweep_last <= n_sweep_last;
            r_report     <= n_report;
            r_done       <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // cursor and ring pointer stay on the screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_x) < COLUMNS) && (32'(r_cur_y) < ROWS) && (32'(r_top) < ROWS))
        else $error("cursor or top row off the screen");

    // every sequence ends back in idle, so two result beats never abut
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beats back to back");

    // only reads carry cell data
    a_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_item.mode != MODE_READ)) |-> (o_result.cell_word == '0))
        else $error("cell data on a non-read result");

    // an accepted beat always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not start work");

    // sweep never runs past its end
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCROLL) || (r_state == S_CLEAR)) |-> (r_sweep <= r_sweep_last))
        else $error("sweep past its last cell");

endmodule

[tb/sv/text_console_cursor_scroll_tb.sv]
module text_console_cursor_scroll_tb
    import txcon_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // the package names only three modes, the fourth code does nothing
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int ITEM_W         = $bits(t_item);
    localparam int ITEM_TARGET    = 1420;
    // no random sender pauses in the closing stretch of the run
    localparam int CALM_TAIL      = 200;
    // a clear walks 2000 cells, so the limit sits well past the silent stretch it makes
    localparam int WATCHDOG_LIMIT = 12000;

    // shadow copy of the console: cell store, cursor and the status beats
    // still owed by the block, oldest first
    class console_shadow;
        logic [15:0] cells [ROWS][COLUMNS];
        int unsigned cur_row;
        int unsigned cur_col;
        t_result     awaited[$];
        int unsigned faults;

        function new();
            faults = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (cells[r, c]) begin
                cells[r][c] = BLANK_CELL;
            end
            cur_row = 0;
            cur_col = 0;
        endfunction

        // apply one accepted command beat and queue the status it must produce
        function void take_command(input t_item cmd);
            t_result res;
            res = '0;
            case (cmd.mode)
                MODE_WRITE: begin
                    if (cmd.char_code == NEWLINE_CODE) begin
                        cur_row++;
                        cur_col = 0;
                    end else begin
                        cells[cur_row][cur_col] =
                            {cmd.back_color, cmd.fore_color, cmd.char_code};
                        cur_col++;
                    end
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // dropped off the bottom: shift every row up, blank the last
                    if (cur_row >= ROWS) begin
                        for (int r = 0; r < ROWS - 1; r++) begin
                            cells[r] = cells[r + 1];
                        end
                        for (int c = 0; c < COLUMNS; c++) begin
                            cells[ROWS - 1][c] = BLANK_CELL;
                        end
                        cur_row = ROWS - 1;
                        cur_col = 0;
                    end
                end
                MODE_CLEAR: begin
                    wipe();
                end
                MODE_READ: begin
                    if (cmd.read_row < ROWS && cmd.read_column < COLUMNS) begin
                        res.cell_word = cells[cmd.read_row][cmd.read_column];
                    end
                end
                default: begin
                    // spare mode leaves everything alone
                end
            endcase
            res.cursor_row    = 5'(cur_row);
            res.cursor_column = 7'(cur_col);
            awaited.push_back(res);
        endfunction

        function void note_fault(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            faults++;
        endfunction

        // compare one status beat with the oldest one owed
        function void match_result(input t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected status beat, expected none, actual %h",
                         $time, got);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (got.cell_word !== want.cell_word) begin
                note_fault("cell_word", want.cell_word, got.cell_word);
            end
            if (got.cursor_row !== want.cursor_row) begin
                note_fault("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            end
            if (got.cursor_column !== want.cursor_column) begin
                note_fault("cursor_column", 16'(want.cursor_column),
                           16'(got.cursor_column));
            end
        endfunction
    endclass

    // clock, reset and block ports; the driven inputs are known from time zero
    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    console_shadow shadow;
    int unsigned   sent_count = 0;
    int unsigned   quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    text_console_cursor_scroll u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // monitor: everything here reads the values from before the edge, since the
    // block and the driver both update through nonblocking assignments
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check first, the beat on the port always belongs to an older command
            if (o_done) begin
                shadow.match_result(o_result);
            end
            if (start && !busy) begin
                shadow.take_command(i_item);
            end
            // watchdog counts edges on which no beat moved either way
            if (o_done || (start && !busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL text_console_cursor_scroll");
                $finish;
            end
        end
    end

    // a command with every field random; callers overwrite what the mode uses
    function automatic t_item random_item(input logic [1:0] mode);
        t_item cmd;
        cmd      = t_item'(ITEM_W'($urandom()));
        cmd.mode = mode;
        return cmd;
    endfunction

    function automatic t_item write_item(input logic [7:0] code);
        t_item cmd;
        cmd           = random_item(MODE_WRITE);
        cmd.char_code = code;
        return cmd;
    endfunction

    function automatic t_item read_item(input int unsigned row, input int unsigned col);
        t_item cmd;
        cmd             = random_item(MODE_READ);
        cmd.read_row    = 5'(row);
        cmd.read_column = 7'(col);
        return cmd;
    endfunction

    // any byte but the newline, for runs that must not break the line
    function automatic logic [7:0] text_byte();
        logic [7:0] code;
        code = 8'($urandom_range(0, 255));
        if (code == NEWLINE_CODE) begin
            code = 8'h2a;
        end
        return code;
    endfunction

    // hold the command until the block takes it; called only on a rising edge,
    // returns on the edge that accepted it, or after a random pause, so the next can follow
    task automatic send_beat(input t_item cmd, input bit may_pause);
        start  <= 1'b1;
        i_item <= cmd;
        do begin
            @(posedge i_clk);
        end while (busy);
        sent_count++;
        // random burst of idle cycles on the sender side
        if (may_pause && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed status beat has come back
    task automatic settle();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (shadow.awaited.size() != 0);
    endtask

    initial begin
        int          pick;
        int          n;
        bit          gappy;
        t_item       cmd;

        shadow = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: fresh store, color and byte extremes, reads at the
        // corners and just off the screen, the spare mode, unused fields, clear
        send_beat(read_item(0, 0), 1'b0);
        send_beat(read_item(ROWS - 1, COLUMNS - 1), 1'b0);
        cmd = write_item(8'h00);
        cmd.fore_color = 4'h0;
        cmd.back_color = 4'h0;
        send_beat(cmd, 1'b0);
        cmd = write_item(8'hff);
        cmd.fore_color = 4'hf;
        cmd.back_color = 4'hf;
        send_beat(cmd, 1'b0);
        cmd = write_item(8'h41);
        cmd.fore_color = 4'ha;
        cmd.back_color = 4'h5;
        send_beat(cmd, 1'b1);
        send_beat(read_item(0, 0), 1'b0);
        send_beat(read_item(0, 1), 1'b0);
        send_beat(read_item(0, 2), 1'b0);
        send_beat(write_item(NEWLINE_CODE), 1'b0);
        send_beat(read_item(ROWS, 0), 1'b0);
        send_beat(read_item(31, 127), 1'b0);
        send_beat(read_item(0, COLUMNS), 1'b0);
        send_beat(read_item(ROWS - 1, COLUMNS), 1'b0);
        send_beat(read_item(ROWS, COLUMNS - 1), 1'b0);
        send_beat(random_item(MODE_SPARE), 1'b0);
        cmd = t_item'({ITEM_W{1'b1}});
        send_beat(cmd, 1'b0);
        // write with the unused read fields all ones
        cmd = write_item(8'h7e);
        cmd.read_row    = '1;
        cmd.read_column = '1;
        send_beat(cmd, 1'b0);
        send_beat(read_item(1, 0), 1'b0);
        send_beat(random_item(MODE_CLEAR), 1'b0);
        send_beat(read_item(0, 0), 1'b0);
        send_beat(read_item(1, 0), 1'b0);

        // sender holds off until the pipe is empty
        settle();

        // random part built from episodes: lines of text, long runs that wrap,
        // newline bursts that scroll, reads near and far, rare clears
        while (sent_count < ITEM_TARGET) begin
            pick  = $urandom_range(0, 99);
            gappy = (sent_count + CALM_TAIL < ITEM_TARGET) && ($urandom_range(0, 2) != 0);
            if (pick < 40) begin
                n = $urandom_range(1, 30);
                repeat (n) send_beat(write_item(text_byte()), gappy);
                if ($urandom_range(0, 3) != 0) begin
                    send_beat(write_item(NEWLINE_CODE), gappy);
                end
            end else if (pick < 50) begin
                // from just short of one full line to over two, so most runs wrap
                n = $urandom_range(COLUMNS - 5, 2 * COLUMNS + 10);
                repeat (n) send_beat(write_item(text_byte()), gappy);
            end else if (pick < 55) begin
                n = $urandom_range(1, ROWS + 5);
                repeat (n) send_beat(write_item(NEWLINE_CODE), gappy);
            end else if (pick < 85) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    case ($urandom_range(0, 6))
                        0: cmd = read_item($urandom_range(0, 31), $urandom_range(0, 127));
                        1, 2: cmd = read_item(shadow.cur_row, $urandom_range(0, COLUMNS - 1));
                        default: cmd = read_item($urandom_range(0, ROWS - 1),
                                                 $urandom_range(0, COLUMNS - 1));
                    endcase
                    send_beat(cmd, gappy);
                end
            end else if (pick < 87) begin
                send_beat(random_item(MODE_CLEAR), gappy);
            end else if (pick < 89) begin
                send_beat(random_item(MODE_SPARE), gappy);
            end else if (pick < 91) begin
                settle();
            end else begin
                // fully random write, newline included now and then
                send_beat(random_item(MODE_WRITE), gappy);
            end
        end

        // wind down: nothing more to send, wait for the last status beats
        start <= 1'b0;
        while (shadow.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (shadow.faults == 0 && shadow.awaited.size() == 0) begin
            $display("PASS text_console_cursor_scroll");
        end else begin
            $display("FAIL text_console_cursor_scroll");
        end
        $finish;
    end

endmodule
